// ===== design/lpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-ahead path tracker package
// Shared types, constants and small functions for the tracker modules.
// ----------------------------------------------------------------------------
package lpt_pkg;

	// Path storage geometry.
	localparam int PATH_DEPTH    = 1024;
	localparam int IDX_W         = $clog2(PATH_DEPTH);
	localparam int LEN_W         = IDX_W + 1;
	localparam int SEARCH_WINDOW = 30;

	// Fixed-point constants.
	localparam int PI_Q13     = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam int PI_Q16     = 205887;
	localparam int GAIN_P_Q16 = 26214;
	localparam int GAIN_D_Q16 = 655;
	localparam int CORDIC_N   = 17;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
	localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
	localparam logic [1:0] CFG_GAIN      = 2'd2;

	typedef struct packed {
		logic               action;
		logic               new_path;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               stop_request;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] linear_velocity;
		logic signed [15:0] angular_velocity;
		logic               target_found;
		logic [9:0]         target_index;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_APPEND,
		OP_NEAR_SETUP,
		OP_READ,
		OP_SQX,
		OP_SQY,
		OP_NEAR_CMP,
		OP_TGT_SETUP,
		OP_TGT_CMP,
		OP_ATAN_INIT,
		OP_NORM,
		OP_ITER,
		OP_ATAN_FIN,
		OP_MUL_LIN,
		OP_MUL_P,
		OP_MUL_D,
		OP_OUT,
		OP_ZERO
	} op_t;

	// Status flags returned to the controller.
	typedef struct packed {
		logic is_tick;
		logic few_points;
		logic stop;
		logic scan_done;
		logic hit;
		logic zero_vec;
		logic norm_done;
		logic iter_last;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_APPEND,
		S_N_SETUP,
		S_N_CHK,
		S_N_RD,
		S_N_SQX,
		S_N_SQY,
		S_N_CMP,
		S_T_SETUP,
		S_T_CHK,
		S_T_RD,
		S_T_SQX,
		S_T_SQY,
		S_T_CMP,
		S_A_INIT,
		S_A_NORM,
		S_A_ITER,
		S_A_FIN,
		S_M_LIN,
		S_M_P,
		S_M_D,
		S_OUT,
		S_ZERO
	} state_t;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic [16:0] atan_step(input logic [4:0] i);
		logic [16:0] v;
		unique case (i)
			5'd0:    v = 17'd51472;
			5'd1:    v = 17'd30386;
			5'd2:    v = 17'd16055;
			5'd3:    v = 17'd8150;
			5'd4:    v = 17'd4091;
			5'd5:    v = 17'd2047;
			5'd6:    v = 17'd1024;
			5'd7:    v = 17'd512;
			5'd8:    v = 17'd256;
			5'd9:    v = 17'd128;
			5'd10:   v = 17'd64;
			5'd11:   v = 17'd32;
			5'd12:   v = 17'd16;
			5'd13:   v = 17'd8;
			5'd14:   v = 17'd4;
			5'd15:   v = 17'd2;
			5'd16:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// Saturate a signed value to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
		logic signed [15:0] r;
		if (v > 35'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -35'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/lpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-ahead path tracker controller
// Sequences appends, the nearest and target scans, the arctangent and the
// command arithmetic by issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module lpt_ctrl
	import lpt_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  stat_t stat,
	output op_t   op,
	output logic  busy
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and operation.
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: state_d = stat.is_tick ? S_N_SETUP : S_APPEND;
			S_APPEND: begin
				op      = OP_APPEND;
				state_d = S_IDLE;
			end
			S_N_SETUP: begin
				op      = OP_NEAR_SETUP;
				state_d = stat.few_points ? S_ZERO : S_N_CHK;
			end
			S_N_CHK: state_d = stat.scan_done ? S_T_SETUP : S_N_RD;
			S_N_RD: begin
				op      = OP_READ;
				state_d = S_N_SQX;
			end
			S_N_SQX: begin
				op      = OP_SQX;
				state_d = S_N_SQY;
			end
			S_N_SQY: begin
				op      = OP_SQY;
				state_d = S_N_CMP;
			end
			S_N_CMP: begin
				op      = OP_NEAR_CMP;
				state_d = S_N_CHK;
			end
			S_T_SETUP: begin
				op      = OP_TGT_SETUP;
				state_d = stat.stop ? S_ZERO : S_T_CHK;
			end
			S_T_CHK: state_d = stat.scan_done ? S_ZERO : S_T_RD;
			S_T_RD: begin
				op      = OP_READ;
				state_d = S_T_SQX;
			end
			S_T_SQX: begin
				op      = OP_SQX;
				state_d = S_T_SQY;
			end
			S_T_SQY: begin
				op      = OP_SQY;
				state_d = S_T_CMP;
			end
			S_T_CMP: begin
				op      = OP_TGT_CMP;
				state_d = stat.hit ? S_A_INIT : S_T_CHK;
			end
			S_A_INIT: begin
				op      = OP_ATAN_INIT;
				state_d = stat.zero_vec ? S_A_FIN : S_A_NORM;
			end
			S_A_NORM: begin
				op      = OP_NORM;
				state_d = stat.norm_done ? S_A_ITER : S_A_NORM;
			end
			S_A_ITER: begin
				op      = OP_ITER;
				state_d = stat.iter_last ? S_A_FIN : S_A_ITER;
			end
			S_A_FIN: begin
				op      = OP_ATAN_FIN;
				state_d = S_M_LIN;
			end
			S_M_LIN: begin
				op      = OP_MUL_LIN;
				state_d = S_M_P;
			end
			S_M_P: begin
				op      = OP_MUL_P;
				state_d = S_M_D;
			end
			S_M_D: begin
				op      = OP_MUL_D;
				state_d = S_OUT;
			end
			S_OUT: begin
				op      = OP_OUT;
				state_d = S_IDLE;
			end
			S_ZERO: begin
				op      = OP_ZERO;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/lpt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-ahead path tracker datapath
// Path memory, tracking state, configuration registers, the squared-distance
// unit, the iterative arctangent and the command arithmetic.
// ----------------------------------------------------------------------------
module lpt_dp
	import lpt_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  op_t             op,
	input  in_item_t        item,
	input  wire             cfg_valid,
	input  wire [1:0]       cfg_index,
	input  wire [19:0]      cfg_data,
	output stat_t           stat,
	output out_item_t       result,
	output logic            done
);

	// Configuration registers.
	logic [19:0] cfg_look_q;
	logic [14:0] cfg_speed_q;
	logic [15:0] cfg_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_look_q  <= 20'd1024;
			cfg_speed_q <= 15'd4096;
			cfg_gain_q  <= 16'd2458;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOOKAHEAD: cfg_look_q  <= cfg_data;
				CFG_MAX_SPEED: cfg_speed_q <= cfg_data[14:0];
				CFG_GAIN:      cfg_gain_q  <= cfg_data[15:0];
				default:       ;
			endcase
		end
	end

	// Tracking state.
	in_item_t           item_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   last_q;
	logic               lvalid_q;
	logic signed [15:0] prev_q;

	// Scan state.
	logic [LEN_W-1:0]   idx_q;
	logic [LEN_W-1:0]   end_q;
	logic [IDX_W-1:0]   near_q;
	logic [IDX_W-1:0]   target_q;
	logic               first_q;
	logic [64:0]        best_q;
	logic [63:0]        sqx_q;
	logic [63:0]        sqy_q;
	logic [39:0]        l2_q;

	// Arctangent and command state.
	logic signed [47:0] x_q, y_q;
	logic signed [20:0] z_q;
	logic [4:0]         it_q;
	logic signed [17:0] e_q;
	logic [32:0]        plin_q;
	logic signed [33:0] pp_q, pd_q;
	out_item_t          res_q;
	logic               done_q;

	// Path memory.
	logic [63:0]        mem [PATH_DEPTH];
	logic [63:0]        rdata_q;
	logic [LEN_W-1:0]   app_base;
	logic               app_we;

	assign app_base = item_q.new_path ? '0 : len_q;
	assign app_we   = (op == OP_APPEND) && (app_base < LEN_W'(PATH_DEPTH));

	always_ff @(posedge clk) begin
		if (app_we) begin
			mem[app_base[IDX_W-1:0]] <= {item_q.pos_y, item_q.pos_x};
		end
		if (op == OP_READ) begin
			rdata_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// Offsets from the robot to the point just read.
	logic signed [32:0] dx, dy;
	logic [31:0]        ax, ay, sq_in;
	logic [63:0]        sq_prod;
	logic [64:0]        d2;

	assign dx = {rdata_q[31], rdata_q[31:0]} - {item_q.pos_x[31], item_q.pos_x};
	assign dy = {rdata_q[63], rdata_q[63:32]} - {item_q.pos_y[31], item_q.pos_y};
	assign ax = dx[32] ? 32'(-dx) : 32'(dx);
	assign ay = dy[32] ? 32'(-dy) : 32'(dy);
	assign sq_in   = (op == OP_SQY) ? ay : ax;
	assign sq_prod = 64'(sq_in) * 64'(sq_in);
	assign d2      = {1'b0, sqx_q} + {1'b0, sqy_q};

	// Nearest-search window.
	logic [LEN_W:0] win_lo, win_hi, last_ext, len_ext;

	assign last_ext = (LEN_W+1)'(last_q);
	assign len_ext  = (LEN_W+1)'(len_q);
	always_comb begin
		if (!lvalid_q) begin
			win_lo = (LEN_W+1)'(1);
			win_hi = len_ext;
		end else begin
			win_lo = (last_ext > (LEN_W+1)'(SEARCH_WINDOW)) ?
				last_ext - (LEN_W+1)'(SEARCH_WINDOW) : (LEN_W+1)'(1);
			win_hi = last_ext + (LEN_W+1)'(SEARCH_WINDOW);
			if (win_hi > len_ext) begin
				win_hi = len_ext;
			end
		end
	end

	// Arctangent helpers.
	logic signed [47:0] ax48, ay48, xs, ys;
	logic signed [20:0] tab, zr;
	logic signed [18:0] rr, eraw, ewrap;

	assign ax48 = x_q[47] ? -x_q : x_q;
	assign ay48 = y_q[47] ? -y_q : y_q;
	assign xs   = x_q >>> it_q;
	assign ys   = y_q >>> it_q;
	assign tab  = $signed({4'b0, atan_step(it_q)});
	assign zr   = (z_q + 21'sd4) >>> 3;

	always_comb begin
		if (zr > 21'(PI_Q13)) begin
			rr = 19'(PI_Q13);
		end else if (zr < -21'(PI_Q13)) begin
			rr = -19'(PI_Q13);
		end else begin
			rr = 19'(zr);
		end
		eraw  = rr - 19'(item_q.heading);
		ewrap = eraw;
		if (eraw < -19'(PI_Q13)) begin
			ewrap = eraw + 19'(TWO_PI_Q13);
		end else if (eraw > 19'(PI_Q13)) begin
			ewrap = eraw - 19'(TWO_PI_Q13);
		end
	end

	// Command arithmetic.
	logic [17:0]        mag;
	logic [33:0]        psum;
	logic signed [22:0] lin_w;
	logic signed [34:0] asum;

	assign mag   = e_q[17] ? 18'(-e_q) : 18'(e_q);
	assign psum  = {1'b0, plin_q} + 34'd4096;
	assign lin_w = $signed({8'b0, cfg_speed_q}) - $signed({2'b0, psum[33:13]});
	assign asum  = 35'(pp_q) + 35'(pd_q) + 35'sd65536;

	// Status to the controller.
	assign stat.is_tick    = item_q.action;
	assign stat.few_points = (len_q < LEN_W'(2));
	assign stat.stop       = item_q.stop_request;
	assign stat.scan_done  = (idx_q >= end_q);
	assign stat.hit        = (d2 >= {25'b0, l2_q});
	assign stat.zero_vec   = (dx == '0) && (dy == '0);
	assign stat.norm_done  = (ax48[47:40] != '0) || (ay48[47:40] != '0);
	assign stat.iter_last  = (it_q == 5'(CORDIC_N - 1));

	// Control state under reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			last_q   <= '0;
			lvalid_q <= 1'b0;
			prev_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (op)
				OP_APPEND: begin
					if (item_q.new_path) begin
						last_q   <= '0;
						lvalid_q <= 1'b0;
					end
					if (app_we) begin
						len_q <= app_base + LEN_W'(1);
					end else begin
						len_q <= app_base;
					end
				end
				OP_TGT_SETUP: begin
					last_q   <= near_q;
					lvalid_q <= 1'b1;
				end
				OP_OUT: begin
					prev_q <= sat16(35'(e_q));
					done_q <= 1'b1;
				end
				OP_ZERO: begin
					prev_q <= '0;
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: item_q <= item;
			OP_NEAR_SETUP: begin
				idx_q   <= LEN_W'(win_lo);
				end_q   <= LEN_W'(win_hi);
				near_q  <= last_q;
				first_q <= 1'b1;
			end
			OP_SQX: sqx_q <= sq_prod;
			OP_SQY: sqy_q <= sq_prod;
			OP_NEAR_CMP: begin
				if (first_q || (d2 < best_q)) begin
					near_q <= idx_q[IDX_W-1:0];
					best_q <= d2;
				end
				first_q <= 1'b0;
				idx_q   <= idx_q + LEN_W'(1);
			end
			OP_TGT_SETUP: begin
				idx_q <= LEN_W'(near_q);
				end_q <= len_q;
				l2_q  <= 40'(cfg_look_q) * 40'(cfg_look_q);
			end
			OP_TGT_CMP: begin
				if (stat.hit) begin
					target_q <= idx_q[IDX_W-1:0];
				end else begin
					idx_q <= idx_q + LEN_W'(1);
				end
			end
			OP_ATAN_INIT: begin
				it_q <= '0;
				if (dx[32]) begin
					x_q <= -{{15{dx[32]}}, dx};
					y_q <= -{{15{dy[32]}}, dy};
					z_q <= dy[32] ? -21'(PI_Q16) : 21'(PI_Q16);
				end else begin
					x_q <= {{15{dx[32]}}, dx};
					y_q <= {{15{dy[32]}}, dy};
					z_q <= '0;
				end
			end
			OP_NORM: begin
				if (!stat.norm_done) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			OP_ITER: begin
				if (!y_q[47]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + tab;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - tab;
				end
				it_q <= it_q + 5'd1;
			end
			OP_ATAN_FIN: e_q <= 18'(ewrap);
			OP_MUL_LIN: plin_q <= 33'(cfg_gain_q) * 33'(mag[16:0]);
			OP_MUL_P:   pp_q <= 34'(e_q) * 34'(GAIN_P_Q16);
			OP_MUL_D:   pd_q <= 34'(prev_q) * 34'(GAIN_D_Q16);
			OP_OUT: begin
				res_q.linear_velocity  <= sat16(35'(lin_w));
				res_q.angular_velocity <= sat16(asum >>> 17);
				res_q.target_found     <= 1'b1;
				res_q.target_index     <= 10'(target_q);
			end
			OP_ZERO: res_q <= '0;
			default: ;
		endcase
	end

	assign result = res_q;
	assign done   = done_q;

endmodule
`default_nettype wire

// ===== design/lookahead_path_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-ahead path tracker
// Stores path points and turns pose ticks into speed and yaw-rate commands.
// ----------------------------------------------------------------------------
// Items are taken while busy is low; one item is worked on at a time. An
// append (action 0) gives no result. A pose tick gives one result, shown
// with done high for a single cycle, that must be taken then: there is no
// back-pressure. The time of a tick with two or more points is set by the
// single-port path memory and the shared squarer, which visit each point of
// the nearest-search window and each point walked in the target search,
// followed by the arctangent (up to about 40 normalising steps and 17
// rotation steps) and the command arithmetic.
// ----------------------------------------------------------------------------
module lookahead_path_tracker_unit
	import lpt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  in_item_t   item,
	output logic       done,
	output out_item_t  result,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [19:0] cfg_data
);

	op_t   op;
	stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	lpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	lpt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

endmodule
`default_nettype wire

// ===== design/lpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Look-ahead path tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lpt_props
	import lpt_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire       done,
	input out_item_t result
);

	// A result only follows a cycle of work.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// Each result strobe lasts one cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// An accepted item makes the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	// Without a target the command is all zeros.
	a_zero_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.target_found) |-> (result.linear_velocity == 16'sd0 &&
		result.angular_velocity == 16'sd0 && result.target_index == 10'd0))
		else $error("non-zero command without a target");

endmodule

bind lookahead_path_tracker_unit lpt_props u_lpt_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

// ===== sim/lpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-ahead path tracker checker
// Watches the item, configuration and result channels of the tracker, keeps
// its own copy of the path and controller state, works out the command that
// each accepted pose tick must give and compares every result with it.
// ----------------------------------------------------------------------------
module lpt_checker
	import lpt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire        busy,
	input  in_item_t   item,
	input  wire        done,
	input  out_item_t  result,
	input  wire        cfg_valid,
	input  wire        cfg_ready,
	input  wire [1:0]  cfg_index,
	input  wire [19:0] cfg_data,
	output int         errors,
	output int         pending
);

	// Arctangent of 2^-i in Q16 radians.
	localparam longint ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	logic [31:0]  pt_x [PATH_DEPTH];
	logic [31:0]  pt_y [PATH_DEPTH];
	int unsigned  n_points;
	int unsigned  near_idx;
	bit           near_known;
	longint       last_err;
	logic [19:0]  look_dist;
	logic [14:0]  speed_max;
	logic [15:0]  speed_gain;
	out_item_t    commands_due [$];

	assign pending = commands_due.size();

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Exact squared distance from the robot to a stored point.
	function automatic logic [65:0] range_sq(int unsigned idx, longint rx, longint ry);
		longint dx, dy;
		logic [65:0] ax, ay;
		dx = longint'($signed(pt_x[idx])) - rx;
		dy = longint'($signed(pt_y[idx])) - ry;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		return ax * ax + ay * ay;
	endfunction

	// Bearing in Q3.13 radians by CORDIC vectoring.
	function automatic longint bearing_q13(longint y, longint x);
		longint z, m, xs, ys, r;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q16 : -PI_Q16;
			x = -x;
			y = -y;
		end
		m = (y < 0) ? -y : y;
		if (x > m) m = x;
		while (m < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q16[i];
			end
		end
		r = (z + 4) >>> 3;
		if (r > PI_Q13) r = PI_Q13;
		if (r < -PI_Q13) r = -PI_Q13;
		return r;
	endfunction

	// Update the path or work out the command for one accepted item.
	task automatic track_item(input in_item_t it);
		longint rx, ry, e, mag, lin, ang;
		int unsigned lo_i, hi_i, best, tgt;
		logic [65:0] d, best_d, reach_sq;
		bit found;
		out_item_t cmd;
		rx = longint'(it.pos_x);
		ry = longint'(it.pos_y);
		if (!it.action) begin
			if (it.new_path) begin
				n_points   = 0;
				near_known = 0;
				near_idx   = 0;
			end
			if (n_points < PATH_DEPTH) begin
				pt_x[n_points] = it.pos_x;
				pt_y[n_points] = it.pos_y;
				n_points++;
			end
			return;
		end
		cmd = '0;
		if (n_points < 2) begin
			last_err = 0;
			commands_due.push_back(cmd);
			return;
		end
		// Nearest point, over the whole path or a window round the last one.
		if (!near_known) begin
			lo_i = 1;
			hi_i = n_points;
		end else begin
			lo_i = (near_idx > SEARCH_WINDOW) ? near_idx - SEARCH_WINDOW : 1;
			hi_i = near_idx + SEARCH_WINDOW;
			if (hi_i > n_points) hi_i = n_points;
		end
		best   = near_idx;
		best_d = '0;
		for (int unsigned i = lo_i; i < hi_i; i++) begin
			d = range_sq(i, rx, ry);
			if (i == lo_i || d < best_d) begin
				best   = i;
				best_d = d;
			end
		end
		near_idx   = best;
		near_known = 1;
		// First point at or beyond the look-ahead distance.
		reach_sq = 66'(look_dist) * 66'(look_dist);
		found    = 0;
		tgt      = 0;
		for (int unsigned i = best; i < n_points; i++) begin
			if (range_sq(i, rx, ry) >= reach_sq) begin
				tgt   = i;
				found = 1;
				break;
			end
		end
		if (!found || it.stop_request) begin
			last_err = 0;
			commands_due.push_back(cmd);
			return;
		end
		e = bearing_q13(longint'($signed(pt_y[tgt])) - ry, longint'($signed(pt_x[tgt])) - rx)
			- longint'(it.heading);
		if (e < -PI_Q13) e = e + TWO_PI_Q13;
		if (e > PI_Q13) e = e - TWO_PI_Q13;
		mag = (e < 0) ? -e : e;
		lin = clamp16(longint'(speed_max) - ((longint'(speed_gain) * mag + 4096) >>> 13));
		ang = clamp16((GAIN_P_Q16 * e + GAIN_D_Q16 * last_err + 65536) >>> 17);
		last_err = clamp16(e);
		cmd.linear_velocity  = 16'(lin);
		cmd.angular_velocity = 16'(ang);
		cmd.target_found     = 1'b1;
		cmd.target_index     = 10'(tgt);
		commands_due.push_back(cmd);
	endtask

	// Follow the channels and compare each result with the oldest command due.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int bad;
		if (!arst_n) begin
			n_points   <= 0;
			near_idx   <= 0;
			near_known <= 0;
			last_err   <= 0;
			look_dist  <= 20'd1024;
			speed_max  <= 15'd4096;
			speed_gain <= 16'd2458;
			errors     <= 0;
			commands_due.delete();
		end else begin
			bad = 0;
			if (done) begin
				if (commands_due.size() == 0) begin
					$error("result with no command due");
					bad++;
				end else begin
					want = commands_due.pop_front();
					if (result.linear_velocity !== want.linear_velocity) begin
						$error("linear_velocity expected %0d got %0d",
							want.linear_velocity, result.linear_velocity);
						bad++;
					end
					if (result.angular_velocity !== want.angular_velocity) begin
						$error("angular_velocity expected %0d got %0d",
							want.angular_velocity, result.angular_velocity);
						bad++;
					end
					if (result.target_found !== want.target_found) begin
						$error("target_found expected %0d got %0d",
							want.target_found, result.target_found);
						bad++;
					end
					if (result.target_index !== want.target_index) begin
						$error("target_index expected %0d got %0d",
							want.target_index, result.target_index);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOOKAHEAD: look_dist  = cfg_data;
					CFG_MAX_SPEED: speed_max  = cfg_data[14:0];
					CFG_GAIN:      speed_gain = cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				track_item(item);
			end
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-ahead path tracker testbench
// Builds paths and sends pose ticks in random bursts under several register
// settings, with a directed opening; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import lpt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	in_item_t    item = '0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = CFG_LOOKAHEAD;
	logic [19:0] cfg_data = '0;
	wire         busy, done, cfg_ready;
	out_item_t   result;
	int          errors, pending;
	int          cycles = 0;
	int          burst_left = 0;
	bit          gaps_on = 1;
	logic [31:0] base_x, base_y;
	int          step_x, step_y, n_pts;

	lookahead_path_tracker_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lpt_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one item and hold it until taken; then maybe pause between bursts.
	task automatic send(input in_item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 8);
			if (gaps_on) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic add_point(input bit fresh, input logic [31:0] x, input logic [31:0] y);
		in_item_t it;
		it = '0;
		it.new_path = fresh;
		it.pos_x    = x;
		it.pos_y    = y;
		it.heading  = 16'($urandom);
		send(it);
	endtask

	task automatic pose_tick(input logic [31:0] x, input logic [31:0] y,
		input int hd, input bit halt);
		in_item_t it;
		it.action       = 1'b1;
		it.new_path     = 1'($urandom);
		it.pos_x        = x;
		it.pos_y        = y;
		it.heading      = 16'(hd);
		it.stop_request = halt;
		send(it);
	endtask

	function automatic int rand_heading();
		return $urandom_range(0, 2 * PI_Q13) - PI_Q13;
	endfunction

	// Wait until the block has given every result and finished any append.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	// One register write, followed by an idle cycle on the channel.
	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Lay down a straight-ish path from a random base with a given step size.
	task automatic build_path(input int count, input int scale);
		base_x = $urandom_range(0, 2097152) - 1048576;
		base_y = $urandom_range(0, 2097152) - 1048576;
		step_x = $urandom_range(0, 2 * scale) - scale;
		step_y = $urandom_range(0, 2 * scale) - scale;
		n_pts  = count;
		for (int i = 0; i < count; i++) begin
			add_point(i == 0, base_x + i * step_x + $urandom_range(0, 64),
				base_y + i * step_y + $urandom_range(0, 64));
		end
	endtask

	initial begin
		int scale, k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ticks on an empty and a one-point path.
		pose_tick(32'd0, 32'd0, 0, 1'b0);
		add_point(1'b1, 32'd100, 32'd100);
		pose_tick(32'd0, 32'd0, PI_Q13, 1'b0);
		// Extremes of coordinates and heading, and a stop request.
		add_point(1'b0, 32'h7fffffff, 32'h80000000);
		add_point(1'b0, 32'h80000000, 32'h7fffffff);
		add_point(1'b0, 32'hffffffff, 32'h00000000);
		pose_tick(32'd0, 32'd0, -PI_Q13, 1'b0);
		pose_tick(32'd0, 32'd0, PI_Q13, 1'b0);
		pose_tick(32'h7fffffff, 32'h7fffffff, 12345, 1'b1);
		pose_tick(32'h80000000, 32'h80000000, -20000, 1'b0);
		settle();
		// Zero look-ahead: robot standing on the target gives a zero bearing.
		write_reg(CFG_LOOKAHEAD, 20'd0);
		write_reg(CFG_MAX_SPEED, 20'h07fff);
		write_reg(CFG_GAIN, 20'h0ffff);
		add_point(1'b1, 32'd0, 32'd0);
		add_point(1'b0, 32'd5000, 32'd0);
		add_point(1'b0, 32'd10000, -32'd3000);
		pose_tick(32'd5000, 32'd0, 9000, 1'b0);
		pose_tick(32'd10000, -32'd3000, -25000, 1'b0);
		pose_tick(32'd4000, 32'd100, 25736, 1'b0);
		settle();
		write_reg(CFG_LOOKAHEAD, 20'hfffff);
		write_reg(CFG_MAX_SPEED, 20'd0);
		write_reg(CFG_GAIN, 20'd0);
		pose_tick(32'd0, 32'd0, 0, 1'b0);
		add_point(1'b0, 32'h40000000, 32'h40000000);
		pose_tick(32'd0, 32'd0, 100, 1'b0);
		settle();

		// Random phases under changing settings.
		for (int ph = 0; ph < 6; ph++) begin
			gaps_on = (ph != 2);
			write_reg(CFG_LOOKAHEAD, (ph == 4) ? 20'hfffff : 20'($urandom_range(0, 20000)));
			write_reg(CFG_MAX_SPEED, (ph == 5) ? 20'h07fff : 20'($urandom_range(0, 32767)));
			write_reg(CFG_GAIN, (ph == 3) ? 20'h0ffff : 20'($urandom_range(0, 8000)));
			scale = (ph == 4) ? 400000 : $urandom_range(200, 6000);
			build_path($urandom_range(2, 12), scale);
			k = 0;
			for (int j = 0; j < 12; j++) begin
				case ($urandom_range(0, 9))
					0: add_point(1'b0, $urandom, $urandom);
					1: pose_tick($urandom, $urandom, rand_heading(), 1'($urandom));
					2: pose_tick(base_x + k * step_x, base_y + k * step_y, rand_heading(),
						1'b1);
					default: begin
						k = k + $urandom_range(0, 3);
						if (k >= n_pts) k = n_pts - 1;
						pose_tick(base_x + k * step_x + $urandom_range(0, 2000) - 1000,
							base_y + k * step_y + $urandom_range(0, 2000) - 1000,
							rand_heading(), 1'b0);
					end
				endcase
			end
			settle();
		end
		repeat (50) @(posedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
